// File: rtl/core/sem_pkg.sv
// Shared types, constants and register codes for the Sobel edge magnitude block.
// Used by the front end, job queue, back end and top under rtl/core; depends on nothing else.
package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W_W   = 11;
  localparam int unsigned CFG_H_W   = 13;
  localparam int unsigned CFG_D_W   = 13;
  localparam int unsigned OUT_ROW_W = 12;
  localparam int unsigned OUT_COL_W = 10;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [PIX_W-1:0]   MAG_SAT      = 8'd255;

  // Register indexes on the configuration channel.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // One magnitude job: the 3x3 neighborhood after edge replication plus position.
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] pix;
    logic [OUT_ROW_W-1:0]       row;
    logic [OUT_COL_W-1:0]       col;
    logic                       last;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_LOAD, F_EMIT} front_state_e;
  typedef enum logic [2:0] {B_IDLE, B_SQUARE, B_ROOT, B_OUT} back_state_e;

endpackage

// File: rtl/core/sem_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module sem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sem_front.sv
// Front end: line stores, 3x3 window, position counters and job classification.
// Depends on sem_pkg and sem_ram; pushes jobs into the job queue.
module sem_front #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sem_pkg::PIX_W-1:0]     in_pixel_i,
  input  logic [sem_pkg::CFG_W_W-1:0]   width_i,
  input  logic [sem_pkg::CFG_H_W-1:0]   height_i,
  output logic                          push_o,
  output sem_pkg::job_t                 job_o,
  input  logic                          full_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CMPC = ((CW > sem_pkg::CFG_W_W) ? CW : sem_pkg::CFG_W_W) + 1;
  localparam int unsigned CMPR = ((RW > sem_pkg::CFG_H_W) ? RW : sem_pkg::CFG_H_W) + 1;

  sem_pkg::front_state_e state_q, state_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [3:0]     mask_q, mask_d;
  logic [sem_pkg::PIX_W-1:0] pix_q;
  logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_q;
  logic [sem_pkg::PIX_W-1:0] top_in, mid_in;
  logic           last_col, last_row, accept, load;
  logic [3:0]     low_bit;

  assign accept = in_valid_i && in_ready_o;
  assign load   = (state_q == sem_pkg::F_LOAD);

  // Two line stores, read at the input column, rewritten in the load cycle.
  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i, .we_i(load), .waddr_i(col_q), .wdata_i(mid_in),
    .raddr_i(col_q), .rdata_o(top_in)
  );
  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i, .we_i(load), .waddr_i(col_q), .wdata_i(pix_q),
    .raddr_i(col_q), .rdata_o(mid_in)
  );

  // Edge tests; an out-of-range register is treated as clamped.
  always_comb begin
    last_col = (width_i == '0) || ((CMPC'(col_q) + CMPC'(1)) >= CMPC'(width_i))
               || (col_q == CW'(MAX_WIDTH - 1));
    last_row = (height_i == '0) || ((CMPR'(row_q) + CMPR'(1)) >= CMPR'(height_i))
               || (row_q == RW'(MAX_HEIGHT - 1));
  end

  assign low_bit = mask_q & (~mask_q + 4'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::F_IDLE: if (in_valid_i) state_d = sem_pkg::F_LOAD;
      sem_pkg::F_LOAD: state_d = sem_pkg::F_EMIT;
      sem_pkg::F_EMIT: if (mask_q == '0) state_d = sem_pkg::F_IDLE;
      default:         state_d = sem_pkg::F_IDLE;
    endcase
  end

  // Outputs, pending job mask and counter updates.
  always_comb begin
    in_ready_o = (state_q == sem_pkg::F_IDLE);
    push_o     = (state_q == sem_pkg::F_EMIT) && (mask_q != '0) && !full_i;
    mask_d     = mask_q;
    col_d      = col_q;
    row_d      = row_q;
    if (load) begin
      mask_d = {last_row && last_col, last_row && (col_q != '0),
                (row_q != '0) && last_col, (row_q != '0) && (col_q != '0)};
    end else if (push_o) begin
      mask_d = mask_q & ~low_bit;
    end
    if ((state_q == sem_pkg::F_EMIT) && (mask_q == '0)) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Job assembly for the lowest pending entry, with edge replication.
  always_comb begin
    logic [1:0] ri [3];
    logic [1:0] ci [3];
    logic       low_rows, edge_cols;
    low_rows  = low_bit[2] || low_bit[3];
    edge_cols = low_bit[1] || low_bit[3];
    if (low_rows) begin
      ri[0] = (row_q == '0) ? 2'd2 : 2'd1;
      ri[1] = 2'd2;
      ri[2] = 2'd2;
    end else begin
      ri[0] = (row_q == RW'(1)) ? 2'd1 : 2'd0;
      ri[1] = 2'd1;
      ri[2] = 2'd2;
    end
    ci[0] = edge_cols ? 2'd1 : 2'd0;
    ci[1] = edge_cols ? 2'd2 : 2'd1;
    ci[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job_o.pix[i][j] = win_q[ri[i]][ci[j]];
      end
    end
    job_o.row  = low_rows ? sem_pkg::OUT_ROW_W'(row_q)
                          : sem_pkg::OUT_ROW_W'(row_q - RW'(1));
    job_o.col  = edge_cols ? sem_pkg::OUT_COL_W'(col_q)
                           : sem_pkg::OUT_COL_W'(col_q - CW'(1));
    job_o.last = low_bit[3];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      mask_q  <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      mask_q  <= mask_d;
      // Window: a new row fills all columns, otherwise shift left.
      if (load) begin
        if (col_q == '0) begin
          for (int j = 0; j < 3; j++) begin
            win_q[0][j] <= top_in;
            win_q[1][j] <= mid_in;
            win_q[2][j] <= pix_q;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            win_q[i][0] <= win_q[i][1];
            win_q[i][1] <= win_q[i][2];
          end
          win_q[0][2] <= top_in;
          win_q[1][2] <= mid_in;
          win_q[2][2] <= pix_q;
        end
      end
    end
  end

  // Pixel capture on transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= in_pixel_i;
    end
  end

  // A load always follows a transfer, and a new pixel waits for the last job.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> load)
    else $error("front: load did not follow transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_ready_o && state_q == sem_pkg::F_IDLE) |-> (mask_q == '0))
    else $error("front: jobs pending while idle");

endmodule

// File: rtl/core/sem_job_fifo.sv
// Short job queue between the front end and the magnitude back end.
// Depends on sem_pkg for the job type.
module sem_job_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sem_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output sem_pkg::job_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sem_pkg::job_t  mem_q [DEPTH];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [AW:0]    count_q;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      count_q <= count_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("job queue underflow");

endmodule

// File: rtl/core/sem_back.sv
// Back end: Sobel gradients, sum of squares and a bit-per-cycle square root.
// Depends on sem_pkg; pops jobs from the queue and drives the output register.
module sem_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  sem_pkg::job_t                 job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]     mag_o,
  output logic [sem_pkg::OUT_ROW_W-1:0] row_o,
  output logic [sem_pkg::OUT_COL_W-1:0] col_o,
  output logic                          last_o
);

  sem_pkg::back_state_e state_q, state_d;
  logic signed [11:0] gx_d, gy_d, gx_q, gy_q;
  logic signed [23:0] sum_w;
  logic [15:0]        sum_q;
  logic               sat_q;
  logic [7:0]         root_q, trial;
  logic [2:0]         bit_q;
  logic [sem_pkg::OUT_ROW_W-1:0] row_q;
  logic [sem_pkg::OUT_COL_W-1:0] col_q;
  logic               last_q;

  // Gradients of the job at the queue head.
  always_comb begin
    logic signed [11:0] p [3][3];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] = $signed({4'd0, job_i.pix[i][j]});
      end
    end
    gx_d = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
    gy_d = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) + (p[2][2] - p[0][2]);
  end

  assign sum_w = (gx_q * gx_q) + (gy_q * gy_q);
  assign trial = root_q | (8'd1 << bit_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::B_IDLE:   if (!empty_i) state_d = sem_pkg::B_SQUARE;
      sem_pkg::B_SQUARE: state_d = sem_pkg::B_ROOT;
      sem_pkg::B_ROOT:   if (bit_q == '0) state_d = sem_pkg::B_OUT;
      sem_pkg::B_OUT:    if (out_ready_i) state_d = sem_pkg::B_IDLE;
      default:           state_d = sem_pkg::B_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    pop_o       = (state_q == sem_pkg::B_IDLE) && !empty_i;
    out_valid_o = (state_q == sem_pkg::B_OUT);
    mag_o       = sat_q ? sem_pkg::MAG_SAT : root_q;
    row_o       = row_q;
    col_o       = col_q;
    last_o      = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      row_q  <= job_i.row;
      col_q  <= job_i.col;
      last_q <= job_i.last;
    end
    if (state_q == sem_pkg::B_SQUARE) begin
      sum_q  <= sum_w[15:0];
      sat_q  <= (sum_w >= 24'sd65536);
      root_q <= '0;
      bit_q  <= 3'd7;
    end
    // One result bit per cycle, most significant first.
    if (state_q == sem_pkg::B_ROOT) begin
      if ((16'(trial) * 16'(trial)) <= sum_q) begin
        root_q <= trial;
      end
      bit_q <= bit_q - 3'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == sem_pkg::B_ROOT) |=> $stable(sum_q))
    else $error("back: square sum changed during root extraction");

endmodule

// File: rtl/core/sobel_edge_magnitude_top.sv
// Sobel 3x3 edge magnitude over a raster pixel stream, with border replication.
// Each pixel passes the front end's idle, load and emit states, with one emit per result it causes (up to 4).
// In the back end each result goes through gradient, squares and an 8-step square root in turn.
// Results trail the input by one row and one pixel; frame_last marks the frame end.
// Reset clears counters, window, queue and control; width resets to 640, height to 480.
// Line stores hold undefined data until written.
module sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] pixel_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] edge_magnitude, [19:8] out_row, [29:20] out_column, [31:30] zero
  output logic [sem_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,  // frame_last
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [sem_pkg::CFG_D_W-1:0]     cfg_data_i
);

  logic [sem_pkg::CFG_W_W-1:0] width_q;
  logic [sem_pkg::CFG_H_W-1:0] height_q;
  sem_pkg::job_t push_job, head_job;
  logic push, full, pop, empty;
  logic [sem_pkg::PIX_W-1:0]     mag;
  logic [sem_pkg::OUT_ROW_W-1:0] row;
  logic [sem_pkg::OUT_COL_W-1:0] col;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WIDTH_RESET;
      height_q <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sem_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[sem_pkg::CFG_W_W-1:0];
        sem_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_pixel_i(s_axis_tdata),
    .width_i(width_q), .height_i(height_q),
    .push_o(push), .job_o(push_job), .full_i(full)
  );

  sem_job_fifo #(.DEPTH(4)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(push_job), .full_o(full),
    .pop_i(pop), .rdata_o(head_job), .empty_o(empty)
  );

  sem_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .job_i(head_job), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .mag_o(mag), .row_o(row), .col_o(col), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, col, row, mag};

endmodule
